### src/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Shared widths, codes, parse phases and the result record.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 3;
   localparam int ERR_W       = 4;

   localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
   localparam logic [BYTE_W-1:0] CH_SEMI  = 8'd59;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

   typedef enum logic [KIND_W-1:0] {
      KIND_FRAME = 3'd0,
      KIND_BODY  = 3'd1,
      KIND_END   = 3'd2,
      KIND_ERR   = 3'd3,
      KIND_LEFT  = 3'd4
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 4'd0,
      ERR_BAD_HEX   = 4'd1,
      ERR_BAD_EXT   = 4'd2,
      ERR_SIZE_LF   = 4'd3,
      ERR_DATA_CR   = 4'd4,
      ERR_DATA_LF   = 4'd5,
      ERR_OVERFLOW  = 4'd6,
      ERR_TRUNCATED = 4'd7,
      ERR_TRAILER   = 4'd8
   } err_type;

   typedef enum logic [11:0] {
      PH_SIZE_FIRST = 12'b0000_0000_0001,
      PH_SIZE       = 12'b0000_0000_0010,
      PH_EXT        = 12'b0000_0000_0100,
      PH_SIZE_LF    = 12'b0000_0000_1000,
      PH_DATA       = 12'b0000_0001_0000,
      PH_DATA_CR    = 12'b0000_0010_0000,
      PH_DATA_LF    = 12'b0000_0100_0000,
      PH_TR_START   = 12'b0000_1000_0000,
      PH_TR_LINE    = 12'b0001_0000_0000,
      PH_TR_CR_END  = 12'b0010_0000_0000,
      PH_TR_CR_LINE = 12'b0100_0000_0000,
      PH_DONE       = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   body_byte;
      err_type             error_code;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
         h.value = 4'(c - 8'd48);
      end else if (c >= 8'd97 && c <= 8'd102) begin
         h.value = 4'(c - 8'd87);
      end else if (c >= 8'd65 && c <= 8'd70) begin
         h.value = 4'(c - 8'd55);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

### src/hcbd_if.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder channels
// Valid/ready channels for the input stream and for the decoded results.
// ----------------------------------------------------------------------------
interface hcbd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [hcbd_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface hcbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hcbd_pkg::KIND_W-1:0]   kind;
   logic [hcbd_pkg::BYTE_W-1:0]   body_byte;
   logic [hcbd_pkg::ERR_W-1:0]    error_code;

   modport source (output valid, output kind, output body_byte, output error_code,
                   input ready);
   modport sink   (input valid, input kind, input body_byte, input error_code,
                   output ready);
endinterface

### src/hcbd_parser.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder parser
// Holds the parse phase and length, and classifies one stream byte per cycle when a transaction fires.
// ----------------------------------------------------------------------------
module hcbd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic                          action,
   input  logic [hcbd_pkg::BYTE_W-1:0]   data_byte,
   output hcbd_pkg::result_type          result
);

   hcbd_pkg::phase_type                  phase_ff, phase_in;
   logic [hcbd_pkg::LENGTH_BITS-1:0]     left_ff, left_in;
   logic [hcbd_pkg::LENGTH_BITS-1:0]     left_dec;
   hcbd_pkg::hex_type                    hex;

   assign hex      = hcbd_pkg::hex_decode(data_byte);
   assign left_dec = left_ff - hcbd_pkg::LENGTH_BITS'(1);

   always_comb begin
      phase_in          = phase_ff;
      left_in           = left_ff;
      result.kind       = hcbd_pkg::KIND_FRAME;
      result.body_byte  = '0;
      result.error_code = hcbd_pkg::ERR_NONE;
      if (phase_ff == hcbd_pkg::PH_DONE) begin
         result.kind = action ? hcbd_pkg::KIND_FRAME : hcbd_pkg::KIND_LEFT;
      end else if (action) begin
         phase_in          = hcbd_pkg::PH_DONE;
         result.kind       = hcbd_pkg::KIND_ERR;
         result.error_code = hcbd_pkg::ERR_TRUNCATED;
      end else begin
         unique case (phase_ff)
            hcbd_pkg::PH_SIZE_FIRST, hcbd_pkg::PH_SIZE: begin
               if (hex.ok) begin
                  // A digit that would shift set bits out of the length overflows.
                  if (left_ff[hcbd_pkg::LENGTH_BITS-1 -: 4] != 4'd0) begin
                     phase_in          = hcbd_pkg::PH_DONE;
                     result.kind       = hcbd_pkg::KIND_ERR;
                     result.error_code = hcbd_pkg::ERR_OVERFLOW;
                  end else begin
                     left_in  = {left_ff[hcbd_pkg::LENGTH_BITS-5:0], hex.value};
                     phase_in = hcbd_pkg::PH_SIZE;
                  end
               end else if (phase_ff == hcbd_pkg::PH_SIZE && data_byte == hcbd_pkg::CH_CR) begin
                  phase_in = hcbd_pkg::PH_SIZE_LF;
               end else if (phase_ff == hcbd_pkg::PH_SIZE &&
                            data_byte == hcbd_pkg::CH_SEMI) begin
                  phase_in = hcbd_pkg::PH_EXT;
               end else begin
                  phase_in          = hcbd_pkg::PH_DONE;
                  result.kind       = hcbd_pkg::KIND_ERR;
                  result.error_code = hcbd_pkg::ERR_BAD_HEX;
               end
            end
            hcbd_pkg::PH_EXT: begin
               if (data_byte == hcbd_pkg::CH_CR) begin
                  phase_in = hcbd_pkg::PH_SIZE_LF;
               end else if (data_byte < hcbd_pkg::CH_SPACE) begin
                  phase_in          = hcbd_pkg::PH_DONE;
                  result.kind       = hcbd_pkg::KIND_ERR;
                  result.error_code = hcbd_pkg::ERR_BAD_EXT;
               end
            end
            hcbd_pkg::PH_SIZE_LF: begin
               if (data_byte != hcbd_pkg::CH_LF) begin
                  phase_in          = hcbd_pkg::PH_DONE;
                  result.kind       = hcbd_pkg::KIND_ERR;
                  result.error_code = hcbd_pkg::ERR_SIZE_LF;
               end else begin
                  phase_in = (left_ff == '0) ? hcbd_pkg::PH_TR_START : hcbd_pkg::PH_DATA;
               end
            end
            hcbd_pkg::PH_DATA: begin
               left_in          = left_dec;
               result.kind      = hcbd_pkg::KIND_BODY;
               result.body_byte = data_byte;
               if (left_dec == '0) begin
                  phase_in = hcbd_pkg::PH_DATA_CR;
               end
            end
            hcbd_pkg::PH_DATA_CR: begin
               if (data_byte != hcbd_pkg::CH_CR) begin
                  phase_in          = hcbd_pkg::PH_DONE;
                  result.kind       = hcbd_pkg::KIND_ERR;
                  result.error_code = hcbd_pkg::ERR_DATA_CR;
               end else begin
                  phase_in = hcbd_pkg::PH_DATA_LF;
               end
            end
            hcbd_pkg::PH_DATA_LF: begin
               if (data_byte != hcbd_pkg::CH_LF) begin
                  phase_in          = hcbd_pkg::PH_DONE;
                  result.kind       = hcbd_pkg::KIND_ERR;
                  result.error_code = hcbd_pkg::ERR_DATA_LF;
               end else begin
                  phase_in = hcbd_pkg::PH_SIZE_FIRST;
                  left_in  = '0;
               end
            end
            hcbd_pkg::PH_TR_START, hcbd_pkg::PH_TR_LINE: begin
               if (data_byte == hcbd_pkg::CH_CR) begin
                  phase_in = (phase_ff == hcbd_pkg::PH_TR_START) ?
                             hcbd_pkg::PH_TR_CR_END : hcbd_pkg::PH_TR_CR_LINE;
               end else if (data_byte == hcbd_pkg::CH_LF) begin
                  phase_in          = hcbd_pkg::PH_DONE;
                  result.kind       = hcbd_pkg::KIND_ERR;
                  result.error_code = hcbd_pkg::ERR_TRAILER;
               end else begin
                  phase_in = hcbd_pkg::PH_TR_LINE;
               end
            end
            hcbd_pkg::PH_TR_CR_END, hcbd_pkg::PH_TR_CR_LINE: begin
               if (data_byte != hcbd_pkg::CH_LF) begin
                  phase_in          = hcbd_pkg::PH_DONE;
                  result.kind       = hcbd_pkg::KIND_ERR;
                  result.error_code = hcbd_pkg::ERR_TRAILER;
               end else if (phase_ff == hcbd_pkg::PH_TR_CR_END) begin
                  phase_in    = hcbd_pkg::PH_DONE;
                  result.kind = hcbd_pkg::KIND_END;
               end else begin
                  phase_in = hcbd_pkg::PH_TR_START;
               end
            end
            default: begin
               // Corrupted phase: behave as finished.
               phase_in    = hcbd_pkg::PH_DONE;
               result.kind = hcbd_pkg::KIND_LEFT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hcbd_pkg::PH_SIZE_FIRST;
         left_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

### src/http_chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder, top level
// Takes one stream byte or finish marker per transaction, returns one result.
// ----------------------------------------------------------------------------
// A result is registered and is valid in the cycle after its input transaction.
// Throughput: one transaction per cycle, limited only by the result register.
// The input side stays ready while the result register drains in the same cycle.
// Reset (synchronous, active high) returns the parser to the first size digit,
// clears the length and empties the result register.
module http_chunked_body_decoder_top (
   input  logic              clock,
   input  logic              reset,
   hcbd_req_if.sink          req_chan,
   hcbd_rsp_if.source        rsp_chan
);

   logic                  req_fire;
   hcbd_pkg::result_type  step_result;
   logic                  rsp_valid_ff, rsp_valid_in;
   hcbd_pkg::result_type  rsp_data_ff;

   // The result register can take a new result when it is empty or being
   // drained this cycle, so back-to-back transactions flow without a bubble.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // The parser holds the phase and length and advances only on a transaction.
   hcbd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .action    (req_chan.action),
      .data_byte (req_chan.data_byte),
      .result    (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_data_ff.kind;
   assign rsp_chan.body_byte  = rsp_data_ff.body_byte;
   assign rsp_chan.error_code = rsp_data_ff.error_code;

   // Every accepted transaction produces a result in the following cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_chan.valid)
      else $error("accepted transaction produced no result");

   // Only error results carry an error code.
   a_err_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind != hcbd_pkg::KIND_ERR) |->
      rsp_chan.error_code == hcbd_pkg::ERR_NONE)
      else $error("error code on a non-error result");

   // Only relayed body bytes carry data.
   a_byte_only_on_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind != hcbd_pkg::KIND_BODY) |->
      rsp_chan.body_byte == '0)
      else $error("data byte on a non-body result");

   // A finish marker never yields a relayed body byte.
   a_finish_no_body: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.action) |=> rsp_chan.kind != hcbd_pkg::KIND_BODY)
      else $error("finish marker produced a body byte");

   // The result register is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result pending after reset");

endmodule
